// File: src/assert_macros.svh
// Assertion macros shared by the list controller and datapath.
// Each macro expects clk and arst_n to be in scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds on every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/pal_pkg.sv
// Shared types and constants for the positional array list.
// Used by pal_ctrl, pal_dp and positional_array_list; depends on nothing.
package pal_pkg;

	localparam int OP_W   = 2;
	localparam int POS_W  = 7;
	localparam int VAL_W  = 32;
	localparam int STAT_W = 2;
	localparam int CNT_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_READ   = 2'd0,
		OP_WRITE  = 2'd1,
		OP_INSERT = 2'd2,
		OP_ERASE  = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE   = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2
	} stat_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;     // latch the incoming transaction
		logic set_status;  // latch the outcome of the position checks
		logic rd_pos;      // read memory at position - 1
		logic rd_src;      // read memory at the shift source
		logic wr_pos_val;  // write the item value at position - 1
		logic wr_move;     // write the read data at the shift target
		logic init_ptr;    // load the shift pointer
		logic step_ptr;    // advance the shift pointer
		logic len_inc;
		logic len_dec;
		logic out_load;    // load the result register
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		op_t  op;
		logic in_list;   // 1 <= position <= length
		logic ins_ok;    // 1 <= position <= length + 1
		logic full;
		logic more;      // shift moves remain
		logic out_free;  // result register can take a new result
	} sts_t;

endpackage

// File: src/pal_ctrl.sv
// Controller state machine for the positional array list.
// Depends on pal_pkg and assert_macros.svh; drives pal_dp through cmd_t.
`include "assert_macros.svh"

module pal_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	output pal_pkg::cmd_t cmd,
	input  pal_pkg::sts_t sts
);
	import pal_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE    = 5'b00001,
		S_EVAL    = 5'b00010,
		S_MOVE_RD = 5'b00100,
		S_MOVE_WR = 5'b01000,
		S_FINISH  = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.set_status = 1'b1;
				state_d        = S_FINISH;
				unique case (sts.op)
					OP_READ: begin
						cmd.rd_pos = sts.in_list;
					end
					OP_WRITE: begin
						cmd.wr_pos_val = sts.in_list;
					end
					OP_INSERT: begin
						if (!sts.full && sts.ins_ok) begin
							cmd.init_ptr = 1'b1;
							state_d      = S_MOVE_RD;
						end
					end
					OP_ERASE: begin
						if (sts.in_list) begin
							cmd.init_ptr = 1'b1;
							state_d      = S_MOVE_RD;
						end
					end
					default: begin
						state_d = S_FINISH;
					end
				endcase
			end
			S_MOVE_RD: begin
				if (sts.more) begin
					cmd.rd_src = 1'b1;
					state_d    = S_MOVE_WR;
				end else begin
					// shifting done: drop the new value in place or shrink
					if (sts.op == OP_INSERT) begin
						cmd.wr_pos_val = 1'b1;
						cmd.len_inc    = 1'b1;
					end else begin
						cmd.len_dec = 1'b1;
					end
					state_d = S_FINISH;
				end
			end
			S_MOVE_WR: begin
				cmd.wr_move  = 1'b1;
				cmd.step_ptr = 1'b1;
				state_d      = S_MOVE_RD;
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_accept_to_eval, in_valid && !in_stall, state_q == S_EVAL, "accepted transaction did not enter evaluation")
	`ASSERT_NEXT(a_move_alternates, state_q == S_MOVE_WR, state_q == S_MOVE_RD, "shift write not followed by shift read")

endmodule

// File: src/pal_dp.sv
// Datapath for the positional array list: element memory, length, shift pointer
// and result register. Depends on pal_pkg and assert_macros.svh; driven by pal_ctrl.
`include "assert_macros.svh"

module pal_dp #(
	parameter int CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pal_pkg::cmd_t                      cmd,
	output pal_pkg::sts_t                      sts,
	input  logic [pal_pkg::OP_W-1:0]           op,
	input  logic [pal_pkg::POS_W-1:0]          position,
	input  logic signed [pal_pkg::VAL_W-1:0]   value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [pal_pkg::VAL_W-1:0]   read_value,
	output logic [pal_pkg::STAT_W-1:0]         status,
	output logic [pal_pkg::CNT_W-1:0]          count,
	output logic                               is_empty
);
	import pal_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > POS_W) ? LW + 1 : POS_W + 1;

	logic [VAL_W-1:0]        mem [CAPACITY];

	op_t                     op_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] val_q;
	logic [LW-1:0]           len_q;
	logic [LW-1:0]           ptr_q;
	stat_t                   stat_q;
	logic signed [VAL_W-1:0] rdata_q;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] read_value_q;
	logic [STAT_W-1:0]       status_q;
	logic [CNT_W-1:0]        count_q;
	logic                    is_empty_q;

	logic [CW-1:0]           pos_w;
	logic [CW-1:0]           len_w;
	logic [CW-1:0]           ptr_w;
	logic [CW-1:0]           pos_m1;
	logic [CW-1:0]           src_w;
	logic                    in_list;
	logic                    ins_ok;
	logic                    full;
	logic                    more;
	stat_t                   stat_d;

	logic                    mem_we;
	logic [AW-1:0]           mem_waddr;
	logic [VAL_W-1:0]        mem_wdata;
	logic                    mem_re;
	logic [AW-1:0]           mem_raddr;

	assign pos_w  = CW'(pos_q);
	assign len_w  = CW'(len_q);
	assign ptr_w  = CW'(ptr_q);
	assign pos_m1 = pos_w - CW'(1);

	assign in_list = (pos_w != '0) && (pos_w <= len_w);
	assign ins_ok  = (pos_w != '0) && (pos_w <= len_w + CW'(1));
	assign full    = (len_w >= CW'(CAPACITY));

	// insert moves downward from the tail, erase moves upward toward the tail
	assign more  = (op_q == OP_INSERT) ? (ptr_w >= pos_w) : (ptr_w + CW'(1) < len_w);
	assign src_w = (op_q == OP_INSERT) ? (ptr_w - CW'(1)) : (ptr_w + CW'(1));

	always_comb begin
		unique case (op_q)
			OP_INSERT: begin
				if (full) begin
					stat_d = ST_FULL;
				end else if (ins_ok) begin
					stat_d = ST_DONE;
				end else begin
					stat_d = ST_BADPOS;
				end
			end
			OP_READ, OP_WRITE, OP_ERASE: begin
				stat_d = in_list ? ST_DONE : ST_BADPOS;
			end
			default: begin
				stat_d = ST_BADPOS;
			end
		endcase
	end

	assign mem_we    = cmd.wr_move | cmd.wr_pos_val;
	assign mem_waddr = cmd.wr_move ? ptr_w[AW-1:0] : pos_m1[AW-1:0];
	assign mem_wdata = cmd.wr_move ? rdata_q : val_q;
	assign mem_re    = cmd.rd_src | cmd.rd_pos;
	assign mem_raddr = cmd.rd_src ? src_w[AW-1:0] : pos_m1[AW-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	// transaction and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q  <= op_t'(op);
			pos_q <= position;
			val_q <= value;
		end
		if (cmd.set_status) begin
			stat_q <= stat_d;
		end
		if (cmd.init_ptr) begin
			ptr_q <= (op_q == OP_INSERT) ? len_q : pos_m1[LW-1:0];
		end else if (cmd.step_ptr) begin
			ptr_q <= (op_q == OP_INSERT) ? (ptr_q - LW'(1)) : (ptr_q + LW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else if (cmd.len_inc) begin
			len_q <= len_q + LW'(1);
		end else if (cmd.len_dec) begin
			len_q <= len_q - LW'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			read_value_q <= ((op_q == OP_READ) && (stat_q == ST_DONE)) ? rdata_q : '0;
			status_q     <= stat_q;
			count_q      <= len_w[CNT_W-1:0];
			is_empty_q   <= (len_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign status     = status_q;
	assign count      = count_q;
	assign is_empty   = is_empty_q;

	assign sts.op       = op_q;
	assign sts.in_list  = in_list;
	assign sts.ins_ok   = ins_ok;
	assign sts.full     = full;
	assign sts.more     = more;
	assign sts.out_free = !out_valid_q || !out_stall;

	`ASSERT_ALWAYS(a_len_bound, CW'(len_q) <= CW'(CAPACITY), "list length above capacity")
	`ASSERT_ALWAYS(a_no_overwrite, !(cmd.out_load && out_valid_q && out_stall), "result overwritten while stalled")

endmodule

// File: src/positional_array_list.sv
// Positional array list: an ordered list of up to CAPACITY signed 32-bit
// elements at 1-based positions, read, overwritten, inserted before or erased
// one transaction at a time. One transaction is handled at a time. For a read,
// an overwrite and any rejected transaction the controller goes from evaluation
// straight to finish; for an insert or erase it passes through a read state and
// a write state for each of the M elements that move (length - position + 1 for
// insert, length - position for erase) and a last read state to finish. The
// result register loads in finish once it is free, and the input is taken again
// in the cycle after the result loads. The element store is a single memory
// with one read and one write port and registered read data, so each moved
// element is read and then written. The result register lets the result wait
// for the consumer while the next transaction is accepted. Memory contents are
// not cleared at reset; only positions 1..length are ever read.
// Depends on pal_pkg, pal_ctrl and pal_dp.

module positional_array_list #(
	parameter int CAPACITY = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [pal_pkg::OP_W-1:0]           op,
	input  logic [pal_pkg::POS_W-1:0]          position,
	input  logic signed [pal_pkg::VAL_W-1:0]   value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [pal_pkg::VAL_W-1:0]   read_value,
	output logic [pal_pkg::STAT_W-1:0]         status,
	output logic [pal_pkg::CNT_W-1:0]          count,
	output logic                               is_empty
);
	import pal_pkg::*;

	cmd_t cmd;
	sts_t sts;

	pal_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	pal_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.op         (op),
		.position   (position),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.read_value (read_value),
		.status     (status),
		.count      (count),
		.is_empty   (is_empty)
	);

endmodule
